/* sv/kwm_pkg.sv */
// Package for the k-way sorted merge: sequencer states, scan control struct,
// field widths and parameter defaults. No dependencies.
`default_nettype none

package kwm_pkg;

    localparam int LANES_DEF      = 8;
    localparam int VALUE_BITS_DEF = 32;

    localparam int LANE_BITS = 3;
    localparam int DATA_BITS = 32;
    localparam int CFG_BITS  = 4;

    localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic cmp_vld;
        logic head_full;
    } t_scan_ctl;

endpackage

`default_nettype wire

/* sv/kwm_in_if.sv */
// Input channel of the k-way sorted merge: valid/ready and one lane beat.
// Depends on kwm_pkg.
`default_nettype none

interface kwm_in_if;
    logic                                valid;
    logic                                ready;
    logic [kwm_pkg::LANE_BITS-1:0]       lane;
    logic signed [kwm_pkg::DATA_BITS-1:0] value;
    logic                                exhausted;

    modport source (output valid, output lane, output value, output exhausted, input ready);
    modport sink   (input valid, input lane, input value, input exhausted, output ready);
endinterface

`default_nettype wire

/* sv/kwm_out_if.sv */
// Output channel of the k-way sorted merge: valid/ready and one result beat.
// Depends on kwm_pkg.
`default_nettype none

interface kwm_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [kwm_pkg::DATA_BITS-1:0] merged_value;
    logic [kwm_pkg::LANE_BITS-1:0]        from_lane;
    logic                                 end_of_merge;

    modport source (output valid, output merged_value, output from_lane,
                    output end_of_merge, input ready);
    modport sink   (input valid, input merged_value, input from_lane,
                    input end_of_merge, output ready);
endinterface

`default_nettype wire

/* sv/kwm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kwm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/kwm_min_unit.sv */
// Shared signed compare unit: tracks the smallest full head over a lane scan,
// lowest lane kept on ties. Depends on kwm_pkg.
`default_nettype none

module kwm_min_unit #(
    parameter int LANES      = kwm_pkg::LANES_DEF,
    parameter int VALUE_BITS = kwm_pkg::VALUE_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire kwm_pkg::t_scan_ctl       i_ctl,
    input  wire logic [$clog2(LANES)-1:0] i_idx,
    input  wire logic [VALUE_BITS-1:0]    i_data,
    output logic                          o_found,
    output logic [$clog2(LANES)-1:0]      o_best_idx,
    output logic [VALUE_BITS-1:0]         o_best_val
);

    logic w_take;

    assign w_take = i_ctl.cmp_vld && i_ctl.head_full &&
                    (!o_found || ($signed(i_data) < $signed(o_best_val)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            o_found <= 1'b0;
        end else if (w_take) begin
            o_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            o_best_idx <= i_idx;
            o_best_val <= i_data;
        end
    end

endmodule

`default_nettype wire

/* sv/k_way_sorted_merge_top.sv */
// K-way sorted merge: lane head store, flag bits, scan sequencer and result
// register. Depends on kwm_pkg, kwm_in_if, kwm_out_if, kwm_ram, kwm_min_unit.
//
// Usage: the host feeds beats on i_in, each carrying a lane number and either
// that lane's next ascending value or an exhausted mark. Once every lane in
// use holds a head or is exhausted, the smallest head (lowest lane on ties)
// leaves on o_out with its lane number; the host must refill that lane next.
// When every lane in use is exhausted, an end-of-merge beat leaves and all
// lane state clears. i_cfg_we/i_cfg_wdata set the lane count (0 acts as 1,
// above LANES acts as LANES); write it only while the block is idle.
// Sequence: a beat that yields a value is accepted, passes a readiness check,
// then the shared compare unit steps through the head RAM of the active lanes
// (one lane per cycle, registered read), and the result register loads. A beat
// that yields nothing ends after the check; an end marker goes from the check
// to the result-register load. The input is ready only while the sequencer is idle.
// A result waits in the output register while o_out.ready is low; the next
// beat is still accepted and worked, and holds at the load step until the
// register frees. Synchronous active-low reset clears all head flags, the
// sequencer and the output register and sets the lane count to 8.
`default_nettype none

module k_way_sorted_merge_top #(
    parameter int LANES      = kwm_pkg::LANES_DEF,
    parameter int VALUE_BITS = kwm_pkg::VALUE_BITS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    kwm_in_if.sink                            i_in,
    kwm_out_if.source                         o_out,
    input  wire logic                         i_cfg_we,
    input  wire logic [kwm_pkg::CFG_BITS-1:0] i_cfg_wdata
);

    localparam int IDX_W = $clog2(LANES);
    localparam int CNT_W = $clog2(LANES + 1);
    localparam int CW    = (CNT_W > kwm_pkg::CFG_BITS) ? CNT_W : kwm_pkg::CFG_BITS;
    localparam int LW    = (CNT_W > kwm_pkg::LANE_BITS) ? CNT_W : kwm_pkg::LANE_BITS;

    kwm_pkg::t_state    r_state, n_state;
    kwm_pkg::t_scan_ctl w_ctl;

    logic [kwm_pkg::CFG_BITS-1:0] r_cfg;
    logic [LANES-1:0]             r_full;
    logic [LANES-1:0]             r_fin;
    logic [LANES-1:0]             w_use;
    logic [CNT_W-1:0]             w_n;
    logic [CW-1:0]                w_cfg_ext;
    logic [CNT_W-1:0]             r_idx;
    logic                         r_cmp_vld;
    logic [IDX_W-1:0]             r_cmp_idx;
    logic                         r_end;
    logic                         r_out_vld;
    logic [kwm_pkg::DATA_BITS-1:0] r_out_val;
    logic [kwm_pkg::LANE_BITS-1:0] r_out_lane;
    logic                         r_out_end;

    logic                         w_accept;
    logic                         w_lane_ok;
    logic [IDX_W-1:0]             w_lane_idx;
    logic                         w_we;
    logic                         w_issue;
    logic                         w_rd_en;
    logic                         w_ready_all;
    logic                         w_all_done;
    logic                         w_scan_done;
    logic                         w_load_out;
    logic [VALUE_BITS-1:0]        w_rdata;
    logic                         w_found;
    logic [IDX_W-1:0]             w_best_idx;
    logic [VALUE_BITS-1:0]        w_best_val;

    // active lane count and lane-in-use mask
    always_comb begin
        w_cfg_ext = CW'(r_cfg);
        if (r_cfg == '0) begin
            w_n = CNT_W'(1);
        end else if (w_cfg_ext > CW'(LANES)) begin
            w_n = CNT_W'(LANES);
        end else begin
            w_n = CNT_W'(r_cfg);
        end
        for (int i = 0; i < LANES; i++) begin
            w_use[i] = (CNT_W'(i) < w_n);
        end
    end

    assign w_accept    = i_in.valid && i_in.ready;
    assign w_lane_ok   = (LW'(i_in.lane) < LW'(w_n));
    assign w_lane_idx  = IDX_W'(i_in.lane);
    assign w_we        = w_accept && w_lane_ok && !i_in.exhausted && !r_fin[w_lane_idx];
    assign w_ready_all = &(r_full | r_fin | ~w_use);
    assign w_all_done  = &(r_fin | ~w_use);
    assign w_issue     = (r_idx < w_n);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= kwm_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kwm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            kwm_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = kwm_pkg::ST_CHECK;
                end
            end
            kwm_pkg::ST_CHECK: begin
                if (!w_ready_all) begin
                    n_state = kwm_pkg::ST_IDLE;
                end else if (w_all_done) begin
                    n_state = kwm_pkg::ST_EMIT;
                end else begin
                    n_state = kwm_pkg::ST_SCAN;
                end
            end
            kwm_pkg::ST_SCAN: begin
                if (!w_issue && !r_cmp_vld) begin
                    n_state = w_found ? kwm_pkg::ST_EMIT : kwm_pkg::ST_IDLE;
                end
            end
            kwm_pkg::ST_EMIT: begin
                if (!r_out_vld || o_out.ready) begin
                    n_state = kwm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = kwm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        i_in.ready        = 1'b0;
        w_rd_en           = 1'b0;
        w_scan_done       = 1'b0;
        w_load_out        = 1'b0;
        w_ctl.clear       = 1'b0;
        w_ctl.cmp_vld     = r_cmp_vld;
        w_ctl.head_full   = r_full[r_cmp_idx];
        case (r_state)
            kwm_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            kwm_pkg::ST_CHECK: begin
                w_ctl.clear = 1'b1;
            end
            kwm_pkg::ST_SCAN: begin
                w_rd_en     = w_issue;
                w_scan_done = !w_issue && !r_cmp_vld;
            end
            kwm_pkg::ST_EMIT: begin
                w_load_out = !r_out_vld || o_out.ready;
            end
            default: begin
                i_in.ready = 1'b0;
            end
        endcase
    end

    // scan counter and compare pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_cmp_vld <= w_rd_en;
            if (r_state == kwm_pkg::ST_CHECK) begin
                r_idx <= '0;
            end else if (w_rd_en) begin
                r_idx <= r_idx + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_idx[IDX_W-1:0];
    end

    // lane flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full <= '0;
            r_fin  <= '0;
            r_end  <= 1'b0;
        end else begin
            if (w_accept && w_lane_ok) begin
                if (i_in.exhausted) begin
                    r_fin[w_lane_idx]  <= 1'b1;
                    r_full[w_lane_idx] <= 1'b0;
                end else if (!r_fin[w_lane_idx]) begin
                    r_full[w_lane_idx] <= 1'b1;
                end
            end
            if (r_state == kwm_pkg::ST_CHECK) begin
                r_end <= w_all_done;
                if (w_ready_all && w_all_done) begin
                    r_full <= '0;
                    r_fin  <= '0;
                end
            end
            if (w_scan_done && w_found) begin
                r_full[w_best_idx] <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_load_out) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_end  <= r_end;
            r_out_val  <= r_end ? '0 : kwm_pkg::DATA_BITS'(w_best_val);
            r_out_lane <= r_end ? '0 : kwm_pkg::LANE_BITS'(w_best_idx);
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.merged_value = r_out_val;
    assign o_out.from_lane    = r_out_lane;
    assign o_out.end_of_merge = r_out_end;

    kwm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (LANES)
    ) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_lane_idx),
        .i_wdata (VALUE_BITS'(i_in.value)),
        .i_re    (w_rd_en),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rdata (w_rdata)
    );

    kwm_min_unit #(
        .LANES      (LANES),
        .VALUE_BITS (VALUE_BITS)
    ) u_min (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_idx      (r_cmp_idx),
        .i_data     (w_rdata),
        .o_found    (w_found),
        .o_best_idx (w_best_idx),
        .o_best_val (w_best_val)
    );

`ifndef SYNTH
    a_flags_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_full & r_fin) == '0)
        else $error("lane both full and exhausted");

    a_cmp_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmp_vld |-> (r_state == kwm_pkg::ST_SCAN))
        else $error("compare step outside scan");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && r_end) |-> (r_full == '0 && r_fin == '0))
        else $error("end marker with lane state left");

    a_value_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load_out && !r_end) |-> w_found)
        else $error("value result without a head");
`endif

endmodule

`default_nettype wire
